FILE: sv/lma_pkg.sv
// ----------------------------------------------------------------------------
// lma_pkg
// Shared types, constants and the log2 mantissa table of the loss accumulator.
// ----------------------------------------------------------------------------
package lma_pkg;

    localparam int MAX_ITEMS      = 1048576;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
    localparam int COUNT_W        = $clog2(MAX_ITEMS + 1);
    localparam int NL_W           = 21;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS      = 64;
    localparam int DCNT_W         = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_SQUARED     = 2'd0;
    localparam logic [1:0] MODE_ABSOLUTE    = 2'd1;
    localparam logic [1:0] MODE_BINARY      = 2'd2;
    localparam logic [1:0] MODE_CATEGORICAL = 2'd3;

    localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;
    localparam logic [47:0] MEAN_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] ONE_Q16  = 17'h1_0000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] abs_diff;
        logic [15:0] prob;
        logic [30:0] label;
        logic        end_of_sample;
        logic        end_of_set;
    } lma_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQ_W, ST_LNQ, ST_LNQ_W, ST_LN1, ST_LN1_W,
        ST_TQ, ST_TQ_W, ST_T1, ST_T1_W, ST_RND, ST_ADD, ST_DIV_INIT,
        ST_DIV, ST_FIN
    } lma_state_t;

    typedef logic [15:0] log_tbl_t [LOG_TABLE_SIZE];

    // fraction bits of log2(1 + i/2^LOG_TABLE_BITS) by repeated squaring in Q1.30
    function automatic log_tbl_t build_log_tbl();
        log_tbl_t    tbl;
        logic [63:0] x;
        logic [15:0] r;
        for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
            x = (64'(LOG_TABLE_SIZE) + 64'(i)) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                r = {r[14:0], 1'b0};
                if (x >= 64'h8000_0000) begin
                    r[0] = 1'b1;
                    x = x >> 1;
                end
            end
            tbl[i] = r;
        end
        return tbl;
    endfunction

    localparam log_tbl_t LOG_TBL = build_log_tbl();

endpackage

FILE: sv/loss_metric_accumulator.sv
// ----------------------------------------------------------------------------
// loss_metric_accumulator
// Streaming mean of squared, absolute, binary or categorical log loss.
// ----------------------------------------------------------------------------
// Each beat is handled by the term sequencer, which has one 32x32 multiplier;
//   the next beat is popped from the queue only once the sequencer is idle.
// At end of set the radix-2 divider runs, then the result sits in the output
//   register; a 4-entry queue decouples input acceptance.
// Reset: synchronous active-low aresetn clears counts, sum and mode to zero.
module loss_metric_accumulator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_true_value,
    input  logic signed [31:0] s_predicted_value,
    input  logic               s_end_of_sample,
    input  logic               s_end_of_set,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [47:0]        m_mean_loss,
    output logic               m_saturated,
    output logic               m_empty_set
);
    import lma_pkg::*;

    lma_entry_t push_entry, pop_entry;
    logic       q_push, q_full, q_pop, q_not_empty;

    lma_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_true_value      (s_true_value),
        .s_predicted_value (s_predicted_value),
        .s_end_of_sample   (s_end_of_sample),
        .s_end_of_set      (s_end_of_set),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (push_entry)
    );

    lma_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty)
    );

    lma_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mean_loss (m_mean_loss),
        .m_saturated (m_saturated),
        .m_empty_set (m_empty_set)
    );

endmodule

FILE: sv/lma_queue.sv
// ----------------------------------------------------------------------------
// lma_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module lma_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lma_pkg::lma_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output lma_pkg::lma_entry_t pop_entry,
    output logic               not_empty
);
    import lma_pkg::*;

    lma_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |=> $stable(wr_ptr_reg))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

FILE: sv/lma_front.sv
// ----------------------------------------------------------------------------
// lma_front
// Holds the mode register, accepts beats and clips them into queue entries.
// ----------------------------------------------------------------------------
module lma_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_true_value,
    input  logic signed [31:0] s_predicted_value,
    input  logic               s_end_of_sample,
    input  logic               s_end_of_set,
    input  logic               q_full,
    output logic               q_push,
    output lma_pkg::lma_entry_t q_entry
);
    import lma_pkg::*;

    logic [1:0]         mode_reg;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        diff     = {s_predicted_value[31], s_predicted_value}
                 - {s_true_value[31], s_true_value};
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

        q_entry.mode          = mode_reg;
        q_entry.abs_diff      = diff_mag[31:0];
        q_entry.end_of_sample = s_end_of_sample;
        q_entry.end_of_set    = s_end_of_set;

        // keep probabilities one LSB away from 0 and 1
        if (s_predicted_value < 32'sd1) begin
            q_entry.prob = 16'd1;
        end else if (s_predicted_value > 32'sd65535) begin
            q_entry.prob = 16'hFFFF;
        end else begin
            q_entry.prob = s_predicted_value[15:0];
        end

        if (s_true_value[31]) begin
            q_entry.label = '0;
        end else if (mode_reg == MODE_BINARY && s_true_value > 32'sd65536) begin
            q_entry.label = 31'(ONE_Q16);
        end else begin
            q_entry.label = s_true_value[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SQUARED;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

endmodule

FILE: sv/lma_back.sv
// ----------------------------------------------------------------------------
// lma_back
// Computes one loss term per entry on a shared multiplier, accumulates it
// and divides the sum by the count at end of set.
// ----------------------------------------------------------------------------
module lma_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  lma_pkg::lma_entry_t q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [47:0]        m_mean_loss,
    output logic               m_saturated,
    output logic               m_empty_set
);
    import lma_pkg::*;

    lma_state_t          state_reg, state_next;
    lma_entry_t          item_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         lsum_reg;
    logic [47:0]         term_reg;
    logic [NL_W-1:0]     nlq_reg, nl1_reg;
    logic [63:0]         sum_reg;
    logic [COUNT_W-1:0]  item_count_reg, sample_count_reg, divisor_reg, div_sel;
    logic                ovf_reg;
    logic [63:0]         quo_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic                m_valid_reg, m_sat_reg, m_empty_reg;
    logic [47:0]         m_mean_reg;

    logic [31:0]         mul_a, mul_b;
    logic [15:0]         ln_x, ln_xn;
    logic [3:0]          ln_e;
    logic [LOG_TABLE_BITS-1:0] ln_idx;
    logic [20:0]         nl2;
    logic [64:0]         sum_add;
    logic [63:0]         sq_rnd, nl_rnd, lsum_rnd;
    logic [COUNT_W:0]    trial;
    logic                out_free, round_up;
    logic [64:0]         mean_full;

    assign out_free = !m_valid_reg || m_ready;
    assign div_sel  = (item_reg.mode == MODE_CATEGORICAL) ? sample_count_reg : item_count_reg;

    // -ln(x)/ln2 in Q.16: leading-one position plus mantissa table
    always_comb begin
        ln_x = (state_reg == ST_LN1) ? 16'(ONE_Q16 - {1'b0, item_reg.prob}) : item_reg.prob;
        ln_e = '0;
        for (int i = 0; i < 16; i++) begin
            if (ln_x[i]) begin
                ln_e = 4'(i);
            end
        end
        ln_xn  = ln_x << (4'd15 - ln_e);
        ln_idx = ln_xn[14 -: LOG_TABLE_BITS];
        nl2    = {5'd16 - {1'b0, ln_e}, 16'b0} - {5'b0, LOG_TBL[ln_idx]};
    end

    always_comb begin
        sum_add  = {1'b0, sum_reg} + {17'b0, term_reg};
        sq_rnd   = prod_reg + 64'h8000;
        nl_rnd   = prod_reg + 64'h8000_0000;
        lsum_rnd = lsum_reg + 64'h8000;
        trial    = {rem_reg, quo_reg[63]};
        round_up = ({rem_reg, 1'b0} >= {1'b0, divisor_reg});
        mean_full = {1'b0, quo_reg} + {64'b0, round_up};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    case (q_entry.mode)
                        MODE_SQUARED:  state_next = ST_SQ;
                        MODE_ABSOLUTE: state_next = ST_ADD;
                        default:       state_next = ST_LNQ;
                    endcase
                end
            end
            ST_SQ:    state_next = ST_SQ_W;
            ST_SQ_W:  state_next = ST_ADD;
            ST_LNQ:   state_next = ST_LNQ_W;
            ST_LNQ_W: state_next = (item_reg.mode == MODE_BINARY) ? ST_LN1 : ST_TQ;
            ST_LN1:   state_next = ST_LN1_W;
            ST_LN1_W: state_next = ST_TQ;
            ST_TQ:    state_next = ST_TQ_W;
            ST_TQ_W:  state_next = (item_reg.mode == MODE_BINARY) ? ST_T1 : ST_RND;
            ST_T1:    state_next = ST_T1_W;
            ST_T1_W:  state_next = ST_RND;
            ST_RND:   state_next = ST_ADD;
            ST_ADD:   state_next = item_reg.end_of_set ? ST_DIV_INIT : ST_IDLE;
            ST_DIV_INIT: state_next = (div_sel == '0) ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: queue pop and multiplier operands
    always_comb begin
        q_pop = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE: q_pop = q_not_empty;
            ST_SQ: begin
                mul_a = item_reg.abs_diff;
                mul_b = item_reg.abs_diff;
            end
            ST_LNQ, ST_LN1: begin
                mul_a = {11'b0, nl2};
                mul_b = LN2_Q32;
            end
            ST_TQ: begin
                mul_a = {1'b0, item_reg.label};
                mul_b = {11'b0, nlq_reg};
            end
            ST_T1: begin
                mul_a = {15'b0, 17'(ONE_Q16 - item_reg.label[16:0])};
                mul_b = {11'b0, nl1_reg};
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                item_reg <= q_entry;
                term_reg <= {16'b0, q_entry.abs_diff};
            end
            ST_SQ_W:  term_reg <= sq_rnd[63:16];
            ST_LNQ_W: nlq_reg  <= nl_rnd[32 +: NL_W];
            ST_LN1_W: nl1_reg  <= nl_rnd[32 +: NL_W];
            ST_TQ_W:  lsum_reg <= prod_reg;
            ST_T1_W:  lsum_reg <= lsum_reg + prod_reg;
            ST_RND:   term_reg <= lsum_rnd[63:16];
            ST_DIV_INIT: begin
                divisor_reg <= div_sel;
                quo_reg     <= sum_reg;
                rem_reg     <= '0;
            end
            ST_DIV: begin
                // one quotient bit per cycle
                if (trial >= {1'b0, divisor_reg}) begin
                    rem_reg <= COUNT_W'(trial - {1'b0, divisor_reg});
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= trial[COUNT_W-1:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            default: begin
                lsum_reg <= lsum_reg;
            end
        endcase
        if (state_reg == ST_FIN && out_free) begin
            m_empty_reg <= (divisor_reg == '0);
            if (divisor_reg == '0) begin
                m_mean_reg <= '0;
                m_sat_reg  <= ovf_reg;
            end else if (mean_full[64:48] != '0) begin
                m_mean_reg <= MEAN_MAX;
                m_sat_reg  <= 1'b1;
            end else begin
                m_mean_reg <= mean_full[47:0];
                m_sat_reg  <= ovf_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            item_count_reg   <= '0;
            sample_count_reg <= '0;
            ovf_reg          <= 1'b0;
            dcnt_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ADD) begin
                // drop items past the count limit
                if (item_count_reg >= COUNT_W'(MAX_ITEMS)) begin
                    ovf_reg <= 1'b1;
                end else begin
                    if (sum_add[64]) begin
                        sum_reg <= '1;
                        ovf_reg <= 1'b1;
                    end else begin
                        sum_reg <= sum_add[63:0];
                    end
                    item_count_reg <= item_count_reg + 1'b1;
                    if (item_reg.end_of_sample) begin
                        sample_count_reg <= sample_count_reg + 1'b1;
                    end
                end
            end
            if (state_reg == ST_DIV_INIT) begin
                dcnt_reg <= '0;
            end else if (state_reg == ST_DIV) begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (state_reg == ST_FIN && out_free) begin
                sum_reg          <= '0;
                item_count_reg   <= '0;
                sample_count_reg <= '0;
                ovf_reg          <= 1'b0;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_mean_loss = m_mean_reg;
    assign m_saturated = m_sat_reg;
    assign m_empty_set = m_empty_reg;

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        item_count_reg <= COUNT_W'(MAX_ITEMS))
        else $error("item count beyond limit");
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < divisor_reg)
        else $error("divider remainder out of range");
    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free |=> m_valid_reg && sum_reg == '0
            && item_count_reg == '0)
        else $error("result not loaded or state not cleared");

endmodule
